[rtl/dspp_pkg.sv]
package dspp_pkg;

    // The divisor sum leaves the block on a fixed-width port and saturates there.
    localparam int SUM_OUT_W = 18;
    localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

[rtl/dspp_rem_unit.sv]
module dspp_rem_unit #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      dividend,
    input  logic [VALUE_WIDTH-1:0]      divisor,
    output dspp_pkg::rem_status_t       status
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;

    // Restoring division: one quotient bit per cycle, only the remainder is kept.
    assign shifted = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            dvd_next   = dividend;
            dsr_next   = divisor;
            count_next = CW'(VALUE_WIDTH);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[VALUE_WIDTH])
                rem_next = shifted[VALUE_WIDTH-1:0];
            else
                rem_next = trial[VALUE_WIDTH-1:0];
            dvd_next   = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

[rtl/divisor_sum_prime_perfect.sv]
// Each trial divisor costs one range check plus a run of the shared bit-serial
// remainder unit; the block works on one request at a time and stalls its input
// while it is busy with one.
// A finished result sits in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and clears
// the output valid; no other state is kept between requests.
module divisor_sum_prime_perfect #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [VALUE_WIDTH-1:0]            value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dspp_pkg::SUM_OUT_W-1:0]    divisor_sum,
    output logic                              is_perfect,
    output logic                              is_prime
);

    // Proper-divisor sums stay below six times the value over this range.
    localparam int SUM_W = VALUE_WIDTH + 3;
    localparam int OUT_W = dspp_pkg::SUM_OUT_W;
    localparam int CMP_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    dspp_pkg::state_t      state_reg, state_next;
    dspp_pkg::rem_status_t rem_status;

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       dsum_reg, dsum_next;
    logic                   perfect_reg, perfect_next;
    logic                   prime_reg, prime_next;
    logic                   rem_start;
    logic [CMP_W-1:0]       sum_ext;
    logic                   sum_sat;

    assign sum_ext = CMP_W'(sum_reg);
    assign sum_sat = sum_ext > CMP_W'(dspp_pkg::SUM_OUT_MAX);

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        div_next       = div_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        dsum_next      = dsum_reg;
        perfect_next   = perfect_reg;
        prime_next     = prime_reg;
        rem_start      = 1'b0;
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            dspp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    value_next = value;
                    div_next   = VALUE_WIDTH'(1);
                    sum_next   = '0;
                    state_next = dspp_pkg::ST_CHECK;
                end
            end
            dspp_pkg::ST_CHECK:
            begin
                if (div_reg <= (value_reg >> 1))
                begin
                    rem_start  = 1'b1;
                    state_next = dspp_pkg::ST_DIVIDE;
                end
                else
                    state_next = dspp_pkg::ST_FINISH;
            end
            dspp_pkg::ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero)
                        sum_next = sum_reg + SUM_W'(div_reg);
                    div_next   = div_reg + VALUE_WIDTH'(1);
                    state_next = dspp_pkg::ST_CHECK;
                end
            end
            dspp_pkg::ST_FINISH:
            begin
                // Wait until the previous result has been taken.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dsum_next      = sum_sat ? dspp_pkg::SUM_OUT_MAX : sum_ext[OUT_W-1:0];
                    perfect_next   = (value_reg != '0) && (sum_reg == SUM_W'(value_reg));
                    prime_next     = (value_reg >= VALUE_WIDTH'(2)) && (sum_reg == SUM_W'(1));
                    state_next     = dspp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dspp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dspp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        div_reg     <= div_next;
        sum_reg     <= sum_next;
        dsum_reg    <= dsum_next;
        perfect_reg <= perfect_next;
        prime_reg   <= prime_next;
    end

    dspp_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (value_reg),
        .divisor  (div_reg),
        .status   (rem_status)
    );

    assign out_valid   = out_valid_reg;
    assign divisor_sum = dsum_reg;
    assign is_perfect  = perfect_reg;
    assign is_prime    = prime_reg;

endmodule

[rtl/dspp_checker.sv]
module dspp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [dspp_pkg::SUM_OUT_W-1:0] divisor_sum,
    input logic                           is_perfect,
    input logic                           is_prime
);

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(divisor_sum)
            && $stable(is_perfect) && $stable(is_prime))
        else $error("stalled result changed");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_prime |-> divisor_sum == dspp_pkg::SUM_OUT_W'(1))
        else $error("prime with a divisor sum other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_perfect |-> !is_prime && divisor_sum != '0)
        else $error("perfect flag inconsistent");

endmodule

bind divisor_sum_prime_perfect dspp_checker u_dspp_checker (.*);

[test/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W = 16;
    localparam int SETTLE_CYCLES = 4 * (VALUE_W + 2) + 10;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_REQUESTS = 70;

    typedef struct packed {
        logic [dspp_pkg::SUM_OUT_W-1:0] divisor_sum;
        logic                           is_perfect;
        logic                           is_prime;
    } verdict_t;

    typedef struct {
        logic [VALUE_W-1:0] number;
        bit                 after_drain;
    } request_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic [VALUE_W-1:0]             value = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [dspp_pkg::SUM_OUT_W-1:0] divisor_sum;
    logic                           is_perfect;
    logic                           is_prime;

    request_t        requests_q[$];
    verdict_t        verdicts_q[$];
    int unsigned     mismatches = 0;
    int unsigned     requests_queued = 0;
    int unsigned     requests_sent = 0;
    int unsigned     burst_start = 0;
    int unsigned     send_wait = 0;
    int unsigned     take_wait = 0;
    bit              send_busy = 1'b1;
    bit              take_busy = 1'b1;
    logic            hold_off = 1'b0;
    longint unsigned run_budget = 0;
    longint unsigned cycle_count = 0;
    longint unsigned cycle_limit = 64'd100_000_000;

    divisor_sum_prime_perfect #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .divisor_sum(divisor_sum),
        .is_perfect (is_perfect),
        .is_prime   (is_prime)
    );

    always #1 clk = ~clk;

    // Divisors are found in pairs up to the square root; the number itself is
    // counted as one of them and taken off again at the end.
    function automatic verdict_t classify_number(logic [VALUE_W-1:0] number);
        longint unsigned n;
        longint unsigned total;
        longint unsigned d;
        verdict_t        v;
        n = number;
        total = 0;
        if (n != 0)
        begin
            for (d = 1; d * d <= n; d++)
            begin
                if (n % d == 0)
                begin
                    total += d;
                    if (n / d != d)
                        total += n / d;
                end
            end
            total -= n;
        end
        v.divisor_sum = (total > dspp_pkg::SUM_OUT_MAX) ? dspp_pkg::SUM_OUT_MAX
                                                        : total[dspp_pkg::SUM_OUT_W-1:0];
        v.is_perfect = (n != 0) && (total == n);
        v.is_prime = (n >= 2) && (total == 1);
        return v;
    endfunction

    task automatic add_request(logic [VALUE_W-1:0] number, bit after_drain);
        request_t r;
        r.number = number;
        r.after_drain = after_drain;
        requests_q.push_back(r);
        requests_queued++;
        run_budget += longint'(number / 2) * (VALUE_W + 2) + 3 + 2 * 19;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : drive
        bit offer;
        offer = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                verdicts_q.push_back(classify_number(value));
                requests_sent++;
                offer = 1'b0;
                if ($urandom_range(0, 9) == 0)
                    send_busy = !send_busy;
                send_wait = send_busy ? $urandom_range(0, 18) : 0;
            end
            if (!offer)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (requests_q.size() > 0 &&
                         (!requests_q[0].after_drain || verdicts_q.size() == 0))
                begin
                    value <= requests_q[0].number;
                    requests_q.pop_front();
                    offer = 1'b1;
                end
            end
        end
        in_valid <= offer;
    end

    always @(posedge clk)
    begin : watch
        verdict_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_q.size() == 0)
                    report_mismatch($sformatf("result with no request waiting, divisor_sum %0d",
                                              divisor_sum));
                else
                begin
                    want = verdicts_q.pop_front();
                    if (divisor_sum !== want.divisor_sum)
                        report_mismatch($sformatf("divisor_sum got %0d expected %0d",
                                                  divisor_sum, want.divisor_sum));
                    if (is_perfect !== want.is_perfect)
                        report_mismatch($sformatf("is_perfect got %b expected %b",
                                                  is_perfect, want.is_perfect));
                    if (is_prime !== want.is_prime)
                        report_mismatch($sformatf("is_prime got %b expected %b",
                                                  is_prime, want.is_prime));
                end
                if ($urandom_range(0, 9) == 0)
                    take_busy = !take_busy;
                take_wait = take_busy ? $urandom_range(0, 18) : 0;
            end
            else if (out_valid && take_wait > 0)
                take_wait--;
        end
        out_stall <= hold_off || (take_wait > 0);
    end

    // The long hold-off starts as the burst of tiny requests begins, so the
    // output register fills and the block has to stall its input.
    initial
    begin
        wait (rst_n === 1'b1 && requests_sent >= burst_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        // Zero and one, small primes, squares, the perfect numbers that fit
        // and the largest value.
        add_request(16'd0, 1'b0);
        add_request(16'd1, 1'b0);
        add_request(16'd2, 1'b0);
        add_request(16'd3, 1'b0);
        add_request(16'd4, 1'b0);
        add_request(16'd6, 1'b0);
        add_request(16'd9, 1'b0);
        add_request(16'd12, 1'b0);
        add_request(16'd28, 1'b0);
        add_request(16'd49, 1'b0);
        add_request(16'd97, 1'b0);
        add_request(16'd255, 1'b0);
        add_request(16'd256, 1'b0);
        add_request(16'd496, 1'b0);
        add_request(16'd8128, 1'b0);
        add_request(16'hFFFF, 1'b0);

        add_request(16'd7, 1'b1);
        burst_start = requests_queued;
        repeat (12)
            add_request(16'($urandom_range(0, 31)), 1'b0);
        add_request(16'($urandom_range(0, 63)), 1'b1);

        repeat (RANDOM_REQUESTS)
        begin
            case ($urandom_range(0, 19))
                0, 1: add_request(16'($urandom_range(256, 2047)), 1'b0);
                2: add_request(16'($urandom_range(0, 3)), 1'b0);
                default: add_request(16'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        cycle_limit = 4 * (run_budget + HOLD_CYCLES) + 10000;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (requests_sent == requests_queued);
        wait (verdicts_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
